// ----- rtl/core/dlbd_pkg.sv -----
`default_nettype none

package dlbd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int CHAN_W  = 8;
    localparam int LEN_W   = 30;
    localparam int COUNT_W = 32;
    localparam int DIGIT_W = 4;

    localparam int MAX_LEN_DIGITS_DEF = 9;

    localparam logic [BYTE_W-1:0] ASCII_HASH = 8'h23;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] ASCII_LF   = 8'h0A;

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_COUNT = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_FOOT  = 3'd4
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SKIP     = 3'd0,
        KIND_DATA     = 3'd1,
        KIND_BLOCK    = 3'd2,
        KIND_RECORD   = 3'd3,
        KIND_BADCNT   = 3'd4,
        KIND_BADFOOT  = 3'd5,
        KIND_BADDIGIT = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   payload;
        logic [CHAN_W-1:0]   channel;
        logic [LEN_W-1:0]    block_length;
        logic [COUNT_W-1:0]  event_count;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/dlbd_ifs.sv -----
`default_nettype none

interface dlbd_byte_if
    import dlbd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dlbd_result_if
    import dlbd_pkg::*;
;
    logic               valid;
    logic               ready;
    kind_t              kind;
    logic [BYTE_W-1:0]  payload;
    logic [CHAN_W-1:0]  channel;
    logic [LEN_W-1:0]   block_length;
    logic [COUNT_W-1:0] event_count;

    modport source (output valid, output kind, output payload, output channel,
                    output block_length, output event_count, input ready);
    modport sink   (input valid, input kind, input payload, input channel,
                    input block_length, input event_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/definite_length_block_deframer_unit.sv -----
// The result of an accepted input beat is registered and offered in the next cycle.
// Throughput: one byte per cycle while the output is not stalled; the parser
// state and the result register both update on every accepted beat, and a
// result waiting at the output is replaced as it is taken.
// Reset: rst_n is asynchronous, active low; it returns the parser to hunting
// for a header with all counters cleared and the output empty.
`default_nettype none

module definite_length_block_deframer_unit
    import dlbd_pkg::*;
#(
    parameter int MAX_LEN_DIGITS = MAX_LEN_DIGITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dlbd_byte_if.sink     in,
    dlbd_result_if.source out
);

    result_t res;
    logic    free;
    logic    take;

    assign in.ready = free;
    assign take     = in.valid && free;

    dlbd_parser #(
        .MAX_LEN_DIGITS (MAX_LEN_DIGITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (in.rx_byte),
        .res     (res)
    );

    dlbd_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (take),
        .res   (res),
        .free  (free),
        .out   (out)
    );

endmodule

`default_nettype wire

// ----- rtl/core/dlbd_parser.sv -----
`default_nettype none

module dlbd_parser
    import dlbd_pkg::*;
#(
    parameter int MAX_LEN_DIGITS = MAX_LEN_DIGITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output result_t                res
);

    phase_t               phase_reg, phase_next;
    logic [DIGIT_W-1:0]   digits_left_reg, digits_left_next;
    logic [LEN_W-1:0]     length_value_reg, length_value_next;
    logic [LEN_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [CHAN_W-1:0]    block_index_reg, block_index_next;
    logic [COUNT_W-1:0]   records_done_reg, records_done_next;

    logic                 is_digit;
    logic [DIGIT_W-1:0]   digit;
    logic                 count_ok;
    logic [DIGIT_W-1:0]   digits_dec;
    logic [LEN_W-1:0]     len_mac;
    logic [LEN_W-1:0]     bytes_dec;
    kind_t                kind;

    // ASCII digits 0x30..0x39 carry their value in the low nibble
    assign is_digit   = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
    assign digit      = rx_byte[DIGIT_W-1:0];
    assign count_ok   = is_digit && (digit <= DIGIT_W'(MAX_LEN_DIGITS));
    assign digits_dec = digits_left_reg - DIGIT_W'(1);
    assign len_mac    = (length_value_reg << 3) + (length_value_reg << 1)
                        + LEN_W'(digit);
    assign bytes_dec  = bytes_left_reg - LEN_W'(1);

    always_comb
    begin
        phase_next = PH_HUNT;
        case (phase_reg)
            PH_COUNT:
            begin
                if (count_ok)
                    phase_next = (digit == '0) ? PH_FOOT : PH_LEN;
            end
            PH_LEN:
            begin
                if (!is_digit)
                    phase_next = PH_HUNT;
                else if (digits_dec != '0)
                    phase_next = PH_LEN;
                else
                    phase_next = (len_mac == '0) ? PH_FOOT : PH_DATA;
            end
            PH_DATA:
            begin
                phase_next = (bytes_dec == '0) ? PH_FOOT : PH_DATA;
            end
            PH_FOOT:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = (rx_byte == ASCII_HASH) ? PH_COUNT : PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        kind              = KIND_SKIP;
        digits_left_next  = digits_left_reg;
        length_value_next = length_value_reg;
        bytes_left_next   = bytes_left_reg;
        block_index_next  = block_index_reg;
        records_done_next = records_done_reg;
        case (phase_reg)
            PH_COUNT:
            begin
                if (count_ok)
                begin
                    length_value_next = '0;
                    if (digit == '0)
                        bytes_left_next = '0;
                    else
                        digits_left_next = digit;
                end
                else
                begin
                    kind             = KIND_BADCNT;
                    block_index_next = '0;
                end
            end
            PH_LEN:
            begin
                if (is_digit)
                begin
                    length_value_next = len_mac;
                    digits_left_next  = digits_dec;
                    if (digits_dec == '0)
                        bytes_left_next = len_mac;
                end
                else
                begin
                    kind             = KIND_BADDIGIT;
                    block_index_next = '0;
                end
            end
            PH_DATA:
            begin
                kind            = KIND_DATA;
                bytes_left_next = bytes_dec;
            end
            PH_FOOT:
            begin
                if (rx_byte == ASCII_LF)
                begin
                    kind              = KIND_RECORD;
                    records_done_next = records_done_reg + COUNT_W'(1);
                    block_index_next  = '0;
                end
                else if (rx_byte == ASCII_SEMI)
                begin
                    kind = KIND_BLOCK;
                    // saturate the block index
                    if (block_index_reg != CHAN_MAX)
                        block_index_next = block_index_reg + CHAN_W'(1);
                end
                else
                begin
                    kind             = KIND_BADFOOT;
                    block_index_next = '0;
                end
            end
            default:
            begin
                if (rx_byte == ASCII_HASH)
                    length_value_next = '0;
            end
        endcase
    end

    assign res.kind         = kind;
    assign res.payload      = (kind == KIND_DATA) ? rx_byte : '0;
    assign res.channel      = block_index_reg;
    assign res.block_length = length_value_next;
    assign res.event_count  = records_done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            digits_left_reg  <= '0;
            length_value_reg <= '0;
            bytes_left_reg   <= '0;
            block_index_reg  <= '0;
            records_done_reg <= '0;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            digits_left_reg  <= digits_left_next;
            length_value_reg <= length_value_next;
            bytes_left_reg   <= bytes_left_next;
            block_index_reg  <= block_index_next;
            records_done_reg <= records_done_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dlbd_out_stage.sv -----
`default_nettype none

module dlbd_out_stage
    import dlbd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  result_t       res,
    output logic          free,
    dlbd_result_if.source out
);

    logic    valid_reg;
    result_t res_reg;

    // a held result may be replaced in the same cycle it is taken
    assign free = !valid_reg || out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out.valid        = valid_reg;
    assign out.kind         = res_reg.kind;
    assign out.payload      = res_reg.payload;
    assign out.channel      = res_reg.channel;
    assign out.block_length = res_reg.block_length;
    assign out.event_count  = res_reg.event_count;

endmodule

`default_nettype wire

// ----- rtl/core/dlbd_checker.sv -----
`default_nettype none

module dlbd_checker
    import dlbd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [KIND_W-1:0]  out_kind,
    input wire logic [BYTE_W-1:0]  out_payload,
    input wire logic [CHAN_W-1:0]  out_channel,
    input wire logic [LEN_W-1:0]   out_block_length,
    input wire logic [COUNT_W-1:0] out_event_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(out_payload) && $stable(out_channel)
            && $stable(out_block_length) && $stable(out_event_count))
        else $error("result changed while stalled");

    a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted byte gave no result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_DATA |-> out_payload == '0)
        else $error("payload set on a non-data result");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind <= KIND_BADDIGIT)
        else $error("result kind out of range");

endmodule

bind definite_length_block_deframer_unit dlbd_checker u_dlbd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in.valid),
    .in_ready         (in.ready),
    .out_valid        (out.valid),
    .out_ready        (out.ready),
    .out_kind         (out.kind),
    .out_payload      (out.payload),
    .out_channel      (out.channel),
    .out_block_length (out.block_length),
    .out_event_count  (out.event_count)
);

`default_nettype wire
